@@ rtl/srtts_pkg.sv @@
// Shared types and constants for the sorted record table with threshold scan.
package srtts_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int TAG_W = 16;
    localparam int WINS_W = 16;
    localparam int STATUS_W = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_QUERY  = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_MATCH    = 2'd2,
        ST_NOMATCH  = 2'd3
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [WINS_W-1:0] wins;
    } record_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic    ins;
        logic    rot;
        record_t new_rec;
    } cell_ctl_t;

    // Where a cell sits relative to the current fill level
    typedef struct packed {
        logic occ;
        logic tail;
    } cell_pos_t;

endpackage

@@ rtl/srtts_cell.sv @@
// One slot of the record chain: holds a record, shifts on insert, rotates on scan.
module srtts_cell (
    input  logic                aclk,
    input  srtts_pkg::cell_ctl_t ctl,
    input  srtts_pkg::cell_pos_t pos,
    input  logic                prev_keep,
    input  srtts_pkg::record_t  left_rec,
    input  srtts_pkg::record_t  right_rec,
    input  srtts_pkg::record_t  head_rec,
    output srtts_pkg::record_t  rec,
    output logic                keep
);
    import srtts_pkg::*;

    record_t rec_reg;
    record_t rec_next;

    // Keep our record when it sorts at or before the incoming one
    assign keep = pos.occ && (rec_reg.wins <= ctl.new_rec.wins);
    assign rec  = rec_reg;

    always_comb begin
        rec_next = rec_reg;
        if (ctl.ins) begin
            if (keep) begin
                rec_next = rec_reg;
            end else if (prev_keep) begin
                rec_next = ctl.new_rec;
            end else begin
                rec_next = left_rec;
            end
        end else if (ctl.rot && pos.occ) begin
            rec_next = pos.tail ? head_rec : right_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule

@@ rtl/sorted_record_table_threshold_scan_unit.sv @@
// Top level of the sorted record table with threshold scan.
//
// Usage
//   Requests arrive on the s_ stream: s_tuser selects insert (0) or query (1);
//   s_tdata carries record_tag, record_wins and min_wins. Results leave on the
//   m_ stream: m_tdata carries status, out_tag and out_wins, m_tlast marks the
//   final result of a request.
//   Records live in a chain of TABLE_DEPTH cells kept in ascending order of
//   wins; an insert lands after every record of equal wins, by
//   each cell either holding, taking the new record or taking its left
//   neighbour's record. A full table refuses the insert.
//   A query rotates the occupied cells once round, presenting one record a
//   cycle at the head cell while the output is not stalled, so it holds off
//   new requests until the scan ends, and leaves the order restored. Since
//   the table is sorted, the matches form a suffix and the final occupied
//   entry carries tlast; no match gives one no-match result.
//   The insert result and the no-match result of an empty table are
//   registered straight from the request. A query first enters the scan
//   state; its results are registered as the records pass the head cell,
//   and the scan covers at most TABLE_DEPTH records.
//   A stalled receiver holds the output register and freezes the scan; a new
//   request is taken while the last result of the previous one waits, if the
//   receiver takes it in the same cycle.
//   Reset empties the table (fill count cleared) and drops any pending result.
module sorted_record_table_threshold_scan_unit #(
    parameter int TABLE_DEPTH = srtts_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // bits from 0: record_tag[15:0], record_wins[31:16], min_wins[47:32]
    input  logic [srtts_pkg::S_TDATA_W-1:0] s_tdata,
    // bit 0: req_type
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // bits from 0: status[1:0], out_tag[17:2], out_wins[33:18], zero pad[39:34]
    output logic [srtts_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import srtts_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     step_reg, step_next;
    logic [WINS_W-1:0] thr_reg, thr_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    record_t           m_rec_reg, m_rec_next;
    logic              m_last_reg, m_last_next;

    record_t           in_rec;
    logic [WINS_W-1:0] in_min;
    logic              out_free;
    logic              accept;
    logic              full;
    logic              hit;
    logic              at_tail;
    cell_ctl_t         ctl;
    record_t           rec  [TABLE_DEPTH];
    logic              keep [TABLE_DEPTH];

    assign in_rec.tag  = s_tdata[TAG_W-1:0];
    assign in_rec.wins = s_tdata[TAG_W+WINS_W-1:TAG_W];
    assign in_min      = s_tdata[S_TDATA_W-1:TAG_W+WINS_W];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(TABLE_DEPTH));

    // Head cell is compared against the latched threshold during the scan
    assign hit     = (rec[0].wins >= thr_reg);
    assign at_tail = ((CW'(step_reg) + CW'(1)) == count_reg);

    assign ctl.ins     = accept && (s_tuser == REQ_INSERT) && !full;
    assign ctl.rot     = (state_reg == SCAN) && out_free;
    assign ctl.new_rec = in_rec;

    // Chain of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        cell_pos_t pos;
        assign pos.occ  = (CW'(i) < count_reg);
        assign pos.tail = (count_reg == CW'(i + 1));

        srtts_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .pos       (pos),
            .prev_keep ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
            .left_rec  (rec[(i == 0) ? 0 : i - 1]),
            .right_rec (rec[(i == TABLE_DEPTH - 1) ? i : i + 1]),
            .head_rec  (rec[0]),
            .rec       (rec[i]),
            .keep      (keep[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        thr_next      = thr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_rec_next    = m_rec_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            IDLE: begin
                if (accept) begin
                    if (s_tuser == REQ_INSERT) begin
                        // Insert answers at once; refuse when full
                        m_valid_next  = 1'b1;
                        m_status_next = full ? ST_FULL : ST_INSERTED;
                        m_rec_next    = '0;
                        m_last_next   = 1'b1;
                        if (!full) begin
                            count_next = count_reg + CW'(1);
                        end
                    end else if (count_reg == '0) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_NOMATCH;
                        m_rec_next    = '0;
                        m_last_next   = 1'b1;
                    end else begin
                        thr_next   = in_min;
                        step_next  = '0;
                        state_next = SCAN;
                    end
                end
            end
            SCAN: begin
                if (out_free) begin
                    // Advance one record; matches form a suffix of the table
                    if (hit) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_MATCH;
                        m_rec_next    = rec[0];
                        m_last_next   = at_tail;
                    end else if (at_tail) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_NOMATCH;
                        m_rec_next    = '0;
                        m_last_next   = 1'b1;
                    end
                    step_next = step_reg + IW'(1);
                    if (at_tail) begin
                        state_next = IDLE;
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        step_reg     <= step_next;
        thr_reg      <= thr_next;
        m_status_reg <= m_status_next;
        m_rec_reg    <= m_rec_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W - TAG_W - WINS_W){1'b0}},
                       m_rec_reg.wins, m_rec_reg.tag, m_status_reg};

endmodule

@@ rtl/srtts_chk.sv @@
// Port-level checker for the sorted record table, bound to the top level.
module srtts_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [srtts_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import srtts_pkg::*;

    // A stalled result holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Every non-match status closes its request
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[STATUS_W-1:0] != ST_MATCH) |-> m_tlast)
        else $error("non-match result without last");

    // Only a match carries a record
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[STATUS_W-1:0] != ST_MATCH)
            |-> (m_tdata[M_TDATA_W-1:STATUS_W] == '0))
        else $error("non-match result carries a record");

    // A request is taken only while no unclosed result sequence is running
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request accepted during a query scan");

endmodule

bind sorted_record_table_threshold_scan_unit srtts_chk u_srtts_chk (.*);

@@ dv/srtts_scan_checker.sv @@
// Checker for the sorted record table scan unit: shadow table, expected results and compare.
`timescale 1ns / 1ps
module srtts_scan_checker
    import srtts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    output int                   mismatch_count,
    output int                   pending
);

    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic [WINS_W-1:0] wins;
        logic              last;
    } scan_result_t;

    record_t      shadow_table [TABLE_DEPTH];
    int           shadow_fill = 0;
    scan_result_t due_results [$];
    int           results_seen = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void queue_result(status_t st, record_t rec, logic last);
        scan_result_t r;
        r.status = st;
        r.tag = rec.tag;
        r.wins = rec.wins;
        r.last = last;
        due_results.push_back(r);
    endfunction

    // Apply one request to the shadow table and queue the results it causes.
    function automatic void apply_table_request(req_t kind, record_t rec,
                                                logic [WINS_W-1:0] min_wins);
        int      pos;
        int      hits;
        record_t blank;
        scan_result_t tail;
        blank = '0;
        if (kind == REQ_INSERT) begin
            if (shadow_fill >= TABLE_DEPTH) begin
                queue_result(ST_FULL, blank, 1'b1);
            end else begin
                // land after every record of equal wins
                pos = 0;
                while (pos < shadow_fill && shadow_table[pos].wins <= rec.wins) pos++;
                for (int i = shadow_fill; i > pos; i--) shadow_table[i] = shadow_table[i-1];
                shadow_table[pos] = rec;
                shadow_fill++;
                queue_result(ST_INSERTED, blank, 1'b1);
            end
        end else begin
            hits = 0;
            for (int i = 0; i < shadow_fill; i++) begin
                if (shadow_table[i].wins >= min_wins) begin
                    queue_result(ST_MATCH, shadow_table[i], 1'b0);
                    hits++;
                end
            end
            if (hits == 0) begin
                queue_result(ST_NOMATCH, blank, 1'b1);
            end else begin
                tail = due_results.pop_back();
                tail.last = 1'b1;
                due_results.push_back(tail);
            end
        end
    endfunction

    always @(posedge aclk) begin
        scan_result_t      want;
        logic [1:0]        got_status;
        logic [TAG_W-1:0]  got_tag;
        logic [WINS_W-1:0] got_wins;
        record_t           req_rec;
        if (!aresetn) begin
            shadow_fill = 0;
            mismatch_count = 0;
            due_results.delete();
        end else begin
            // results first: a result at this edge belongs to an earlier request
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[1:0];
                got_tag = m_tdata[17:2];
                got_wins = m_tdata[33:18];
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result %0d arrived with nothing due: status %0d tag %h wins %h last %b",
                        results_seen, got_status, got_tag, got_wins, m_tlast));
                end else begin
                    want = due_results.pop_front();
                    if (got_status !== want.status || got_tag !== want.tag ||
                        got_wins !== want.wins || m_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            "result %0d: status %0d tag %h wins %h last %b, want %0d %h %h %b",
                            results_seen, got_status, got_tag, got_wins, m_tlast,
                            want.status, want.tag, want.wins, want.last));
                    end
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                req_rec.tag = s_tdata[15:0];
                req_rec.wins = s_tdata[31:16];
                apply_table_request(req_t'(s_tuser), req_rec, s_tdata[47:32]);
            end
        end
        pending = due_results.size();
    end

endmodule

@@ dv/tb_sorted_record_table_threshold_scan_unit.sv @@
// Testbench top for the sorted record table scan unit: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module tb_sorted_record_table_threshold_scan_unit;
    import srtts_pkg::*;

    localparam int TABLE_DEPTH     = DEFAULT_TABLE_DEPTH;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_REQUESTS = 202;
    localparam int INSERT_PCT      = 55;
    // Longest legal quiet spell is a run of receiver stalls or sender gaps;
    // at 79 % idling a run of this length is practically impossible.
    localparam int QUIET_LIMIT     = 2000;
    // A query scans at most TABLE_DEPTH cells after the request.
    localparam int DRAIN_CYCLES    = 2 * TABLE_DEPTH + 8;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // bits from 0: record_tag[15:0], record_wins[31:16], min_wins[47:32]
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // bit 0: req_type
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // bits from 0: status[1:0], out_tag[17:2], out_wins[33:18], zero pad[39:34]
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int mismatches;
    int pending;
    int send_idle_pct = 26;
    int recv_idle_pct = 79;
    int quiet_cycles = 0;
    // wins already offered for insert, used to aim query thresholds at real keys
    logic [WINS_W-1:0] offered_wins [$];

    always #CLK_HALF aclk = ~aclk;

    sorted_record_table_threshold_scan_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    srtts_scan_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) scan_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatches),
        .pending       (pending)
    );

    // Stall the receiver at random, redrawn every falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL sorted_record_table_threshold_scan_unit");
            $finish;
        end
    end

    // Present one request from a falling edge and hold it until accepted.
    // Return at the falling edge after acceptance, with valid still high, so
    // the next call either keeps it high or drops it, never both in one step.
    task automatic send_request(input req_t kind, input logic [TAG_W-1:0] tag,
                                input logic [WINS_W-1:0] wins,
                                input logic [WINS_W-1:0] min_wins);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {min_wins, wins, tag};
        if (kind == REQ_INSERT) offered_wins.push_back(wins);
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Draw one random request: inserts favour clustered keys so that ties
    // occur, queries favour thresholds at or just above keys already seen.
    task automatic send_random_request();
        req_t              kind;
        logic [TAG_W-1:0]  tag;
        logic [WINS_W-1:0] wins;
        logic [WINS_W-1:0] min_wins;
        int                pick;
        tag = 16'($urandom);
        wins = 16'($urandom);
        min_wins = 16'($urandom);
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < INSERT_PCT) begin
            kind = REQ_INSERT;
            if (pick < 40) begin
                wins = 16'($urandom_range(0, 7)) << 13;
            end else if (pick < 50) begin
                wins = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
        end else begin
            kind = REQ_QUERY;
            if (pick < 15) begin
                min_wins = 16'h0000;
            end else if (pick < 25) begin
                min_wins = 16'hFFFF;
            end else if (pick < 60 && offered_wins.size() > 0) begin
                min_wins = offered_wins[$urandom_range(0, offered_wins.size() - 1)]
                           + 16'($urandom_range(0, 1));
            end
        end
        send_request(kind, tag, wins, min_wins);
    endtask

    initial begin
        // hold reset over the first rising edges, release on a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // query the empty table at both threshold extremes
        send_request(REQ_QUERY, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_request(REQ_QUERY, 16'h0000, 16'h0000, 16'hFFFF);
        // extremes of tag and wins, then ties at low, middle and top keys
        send_request(REQ_INSERT, 16'h0000, 16'h0000, 16'($urandom));
        send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'($urandom));
        send_request(REQ_INSERT, 16'h1234, 16'h0100, 16'($urandom));
        send_request(REQ_INSERT, 16'hA5A5, 16'h0100, 16'($urandom));
        send_request(REQ_INSERT, 16'h5A5A, 16'h0100, 16'($urandom));
        send_request(REQ_INSERT, 16'h0001, 16'h0000, 16'($urandom));
        send_request(REQ_INSERT, 16'hFFFE, 16'hFFFF, 16'($urandom));
        send_request(REQ_INSERT, 16'h8000, 16'h00FF, 16'($urandom));
        // zero threshold returns the whole table in order
        send_request(REQ_QUERY, 16'($urandom), 16'($urandom), 16'h0000);
        // thresholds on, just above and just below a tied key
        send_request(REQ_QUERY, 16'($urandom), 16'($urandom), 16'h0100);
        send_request(REQ_QUERY, 16'($urandom), 16'($urandom), 16'h0101);
        send_request(REQ_QUERY, 16'($urandom), 16'($urandom), 16'h00FF);
        send_request(REQ_QUERY, 16'($urandom), 16'($urandom), 16'h0001);
        // top threshold matches only the top key; a middle one above a new 7FFF key hits only the top key
        send_request(REQ_QUERY, 16'($urandom), 16'($urandom), 16'hFFFF);
        send_request(REQ_INSERT, 16'h7FFF, 16'h7FFF, 16'($urandom));
        send_request(REQ_QUERY, 16'($urandom), 16'($urandom), 16'h8000);

        // random part: the table fills early, after which inserts are refused
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 79;
                recv_idle_pct = 26;
            end else if (i == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_request();
        end
        s_tvalid <= 1'b0;

        // drain: wait for every due result, then watch for stray ones
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0) begin
            $display("PASS sorted_record_table_threshold_scan_unit");
        end else begin
            $display("FAIL sorted_record_table_threshold_scan_unit");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/srtts_pkg.sv
rtl/srtts_cell.sv
rtl/sorted_record_table_threshold_scan_unit.sv
rtl/srtts_chk.sv
dv/srtts_scan_checker.sv
dv/tb_sorted_record_table_threshold_scan_unit.sv
